@@ src/dhtcrc_pkg.sv @@
// dhtcrc_pkg: shared types, constants and the crc-16/modbus byte update
// used by the front end, frame queue and packet back end.
// no dependencies.
package dhtcrc_pkg;

	localparam int FRAME_BITS  = 40;
	localparam int CNT_W       = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam int PKT_BYTES   = 9;
	localparam int CRC_BYTES   = 6;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [15:0] THRESH_RST  = 16'd30;
	localparam logic [7:0]  DEV_ID_RST  = 8'h02;
	localparam logic [7:0]  FUNC_RST    = 8'h03;
	localparam logic [7:0]  TRAILER_RST = 8'hF0;

	// register indexes of the configuration port
	localparam logic [1:0] REG_THRESH  = 2'd0;
	localparam logic [1:0] REG_DEV_ID  = 2'd1;
	localparam logic [1:0] REG_FUNC    = 2'd2;
	localparam logic [1:0] REG_TRAILER = 2'd3;

	// packet byte positions
	localparam logic [3:0] POS_DEV_ID  = 4'd0;
	localparam logic [3:0] POS_FUNC    = 4'd1;
	localparam logic [3:0] POS_D0      = 4'd2;
	localparam logic [3:0] POS_D1      = 4'd3;
	localparam logic [3:0] POS_D2      = 4'd4;
	localparam logic [3:0] POS_D3      = 4'd5;
	localparam logic [3:0] POS_CRC_LO  = 4'd6;
	localparam logic [3:0] POS_CRC_HI  = 4'd7;
	localparam logic [3:0] POS_TRAILER = 4'd8;

	// one checked frame handed from front to back
	typedef struct packed {
		logic [31:0] data;   // d0 in [31:24] .. d3 in [7:0]
		logic        ok;     // checksum matched
	} frame_t;

	// packet header and trailer bytes
	typedef struct packed {
		logic [7:0] device_id;
		logic [7:0] function_code;
		logic [7:0] trailer_byte;
	} pkt_cfg_t;

	// crc-16/modbus update by one byte, reflected, eight shift steps
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) c = (c >> 1) ^ CRC_POLY;
			else c = c >> 1;
		end
		return c;
	endfunction

endpackage

@@ src/dhtcrc_front.sv @@
// dhtcrc_front: takes one beat per dht11 bit, thresholds it, builds the
// 40-bit frame and pushes checked frames into the queue.
// depends on dhtcrc_pkg.
module dhtcrc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // [15:0] high_ticks
	input  logic                  s_tuser,   // [0] frame_start
	input  logic [15:0]           thresh,
	input  logic                  q_full,
	output logic                  q_push,
	output dhtcrc_pkg::frame_t    q_entry
);
	import dhtcrc_pkg::*;

	logic [CNT_W-1:0] bit_cnt_q;
	logic [39:0]      shift_q;
	logic [CNT_W-1:0] base_cnt;
	logic [39:0]      base_shift;
	logic [CNT_W-1:0] next_cnt;
	logic [39:0]      next_shift;
	logic             rx_bit;
	logic             accept;
	logic             complete;
	logic [7:0]       sum_calc;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// bit decision and frame assembly, frame_start drops any partial frame
	always_comb begin
		base_cnt   = s_tuser ? '0 : bit_cnt_q;
		base_shift = s_tuser ? '0 : shift_q;
		rx_bit     = s_tdata > thresh;
		next_shift = {base_shift[38:0], rx_bit};
		next_cnt   = base_cnt + CNT_W'(1);
		complete   = next_cnt == CNT_W'(FRAME_BITS);
	end

	// checksum check on the completed frame
	always_comb begin
		sum_calc = next_shift[39:32] + next_shift[31:24] + next_shift[23:16]
			+ next_shift[15:8];
		q_entry.data = next_shift[39:8];
		q_entry.ok   = sum_calc == next_shift[7:0];
	end

	assign q_push = accept && complete;

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			shift_q   <= '0;
		end else if (accept) begin
			if (complete) begin
				bit_cnt_q <= '0;
				shift_q   <= '0;
			end else begin
				bit_cnt_q <= next_cnt;
				shift_q   <= next_shift;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q < CNT_W'(FRAME_BITS))
		else $error("front bit count reached a full frame without clearing");

endmodule

@@ src/dhtcrc_queue.sv @@
// dhtcrc_queue: short queue of checked frames between front and back end.
// depends on dhtcrc_pkg.
module dhtcrc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dhtcrc_pkg::frame_t    push_data,
	output logic                  full,
	input  logic                  pop,
	output logic                  rd_valid,
	output dhtcrc_pkg::frame_t    rd_data
);
	import dhtcrc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	frame_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = count_q == CNT_QW'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) count_q <= count_q + CNT_QW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_QW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("frame pushed into a full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_QW'(QUEUE_DEPTH))
		else $error("queue count above depth");

endmodule

@@ src/dhtcrc_back.sv @@
// dhtcrc_back: pops checked frames and streams the nine-byte packet with
// its crc-16/modbus, or a single error beat, through an output register.
// depends on dhtcrc_pkg.
module dhtcrc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  dhtcrc_pkg::frame_t    q_data,
	output logic                  q_pop,
	input  dhtcrc_pkg::pkt_cfg_t  cfg,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [7:0] packet_byte
	output logic                  m_tlast,
	output logic                  m_tuser    // [0] checksum_error
);
	import dhtcrc_pkg::*;

	logic        busy_q;
	logic [3:0]  idx_q;
	frame_t      frame_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic        out_err_q;
	logic        out_free;
	logic        load;
	logic [7:0]  sel_byte;

	assign out_free = !out_valid_q || m_tready;
	assign load     = busy_q && out_free;
	assign q_pop    = !busy_q && q_valid;

	// packet byte select
	always_comb begin
		unique case (idx_q)
			POS_DEV_ID:  sel_byte = cfg.device_id;
			POS_FUNC:    sel_byte = cfg.function_code;
			POS_D0:      sel_byte = frame_q.data[31:24];
			POS_D1:      sel_byte = frame_q.data[23:16];
			POS_D2:      sel_byte = frame_q.data[15:8];
			POS_D3:      sel_byte = frame_q.data[7:0];
			POS_CRC_LO:  sel_byte = crc_q[7:0];
			POS_CRC_HI:  sel_byte = crc_q[15:8];
			POS_TRAILER: sel_byte = cfg.trailer_byte;
			default:     sel_byte = '0;
		endcase
	end

	// frame payload
	always_ff @(posedge clk) begin
		if (q_pop) frame_q <= q_data;
		if (q_pop) crc_q <= CRC_INIT;
		else if (load && idx_q < 4'(CRC_BYTES)) crc_q <= crc_byte(crc_q, sel_byte);
		if (load) begin
			out_byte_q <= frame_q.ok ? sel_byte : 8'h00;
			out_last_q <= !frame_q.ok || idx_q == POS_TRAILER;
			out_err_q  <= !frame_q.ok;
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (load) begin
				idx_q <= idx_q + 4'd1;
				if (!frame_q.ok || idx_q == POS_TRAILER) busy_q <= 1'b0;
			end
			if (load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'h00))
		else $error("error beat not a lone zero beat");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < 4'(PKT_BYTES))
		else $error("packet index past trailer");

endmodule

@@ src/dht11_frame_to_crc16_packet_unit.sv @@
// dht11_frame_to_crc16_packet_unit: top level, configuration registers and
// the front end, frame queue and packet back end.
// depends on dhtcrc_pkg, dhtcrc_front, dhtcrc_queue, dhtcrc_back.
//
// Usage: each slave beat is one dht11 data bit; tdata carries the length of
// its high phase in ticks and tuser marks the first bit of a new frame. A
// bit is one when its length exceeds bit_threshold. Bits are taken one per
// cycle while tready is high. When the fortieth bit arrives the frame is
// checked and queued; the back end then sends nine master beats (device id,
// function code, four data bytes, crc low, crc high, trailer, tlast on the
// trailer) or, on a checksum mismatch, one zero beat with tuser and tlast set.
// Flow: the queued frame is popped into the back end's frame register, then
// one beat per cycle goes out while the receiver takes them; a full packet
// holds the back end for taking the frame and nine byte loads by its byte
// sequencer, with one crc byte update per load. The two-entry frame queue
// lets bits keep arriving meanwhile; slave tready falls only when the
// queue is full.
// Reset clears the bit count, frame, queue and output valid, and loads the
// register defaults. A stalled receiver holds the current beat in the
// output register; the back end and, once the queue fills, the front end wait.
module dht11_frame_to_crc16_packet_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] high_ticks
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] packet_byte
	output logic        m_tlast,
	output logic        m_tuser,   // [0] checksum_error
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import dhtcrc_pkg::*;

	logic [15:0] thresh_q;
	pkt_cfg_t    pkt_cfg_q;
	logic        q_full;
	logic        q_push;
	frame_t      q_entry;
	logic        q_pop;
	logic        q_valid;
	frame_t      q_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q                <= THRESH_RST;
			pkt_cfg_q.device_id     <= DEV_ID_RST;
			pkt_cfg_q.function_code <= FUNC_RST;
			pkt_cfg_q.trailer_byte  <= TRAILER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESH:  thresh_q                <= cfg_data;
				REG_DEV_ID:  pkt_cfg_q.device_id     <= cfg_data[7:0];
				REG_FUNC:    pkt_cfg_q.function_code <= cfg_data[7:0];
				REG_TRAILER: pkt_cfg_q.trailer_byte  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	dhtcrc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.thresh   (thresh_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	dhtcrc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_entry),
		.full      (q_full),
		.pop       (q_pop),
		.rd_valid  (q_valid),
		.rd_data   (q_data)
	);

	dhtcrc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.cfg      (pkt_cfg_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

@@ dv/dht11_frame_to_crc16_packet_unit_tb.sv @@
// dht11_frame_to_crc16_packet_unit_tb: self-checking bench for the dht11 bit receiver and
// crc-16/modbus packet builder, random stalls on both streams, predictor kept in the bench.
// depends on dhtcrc_pkg and dht11_frame_to_crc16_packet_unit.
module dht11_frame_to_crc16_packet_unit_tb;
	import dhtcrc_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 32;

	// one dht11 data bit as driven on the slave side
	typedef struct packed {
		logic [15:0] ticks;
		logic        start;
	} dht_bit_t;

	// one packet beat as seen on the master side
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} pkt_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_THRESH;
	logic [15:0] cfg_data = '0;

	dht_bit_t  bit_q[$];
	pkt_beat_t pkt_expect_q[$];

	// bench copy of the registers and receive state
	logic [15:0] thr_reg;
	logic [7:0]  dev_reg;
	logic [7:0]  func_reg;
	logic [7:0]  trail_reg;
	logic [5:0]  rx_count;
	logic [39:0] rx_frame;

	int       errors = 0;
	int       idle_cycles = 0;
	int       gen_bits = 0;
	int       tx_gap = 0;
	int       rx_stall = 0;
	bit       tx_quiet = 1'b0;
	bit       rx_quiet = 1'b0;
	bit       bit_taken = 1'b0;
	dht_bit_t next_bit;

	dht11_frame_to_crc16_packet_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),     // [15:0] high_ticks
		.s_tuser(s_tuser),     // [0] frame_start
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),     // [7:0] packet_byte
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),     // [0] checksum_error
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// crc-16/modbus over six bytes, first byte in the top bits
	function automatic logic [15:0] modbus_crc(input logic [47:0] msg);
		logic [15:0] crc;
		crc = CRC_INIT;
		for (int i = 0; i < 6; i++) begin
			crc = crc ^ {8'h00, msg[47 - 8 * i -: 8]};
			for (int b = 0; b < 8; b++) begin
				if (crc[0]) crc = (crc >> 1) ^ CRC_POLY;
				else crc = crc >> 1;
			end
		end
		return crc;
	endfunction

	// expected beats for one accepted bit
	task automatic predict_packet(input logic [15:0] ticks, input logic start);
		logic [7:0]  d0, d1, d2, d3, sum_rx, sum_calc;
		logic [15:0] crc;
		logic [7:0]  pkt [9];
		if (start) begin
			rx_count = '0;
			rx_frame = '0;
		end
		rx_frame = {rx_frame[38:0], ticks > thr_reg};
		rx_count = rx_count + 6'd1;
		if (rx_count == FRAME_BITS) begin
			{d0, d1, d2, d3, sum_rx} = rx_frame;
			rx_count = '0;
			rx_frame = '0;
			sum_calc = d0 + d1 + d2 + d3;
			if (sum_calc != sum_rx) begin
				pkt_expect_q.push_back({8'h00, 1'b1, 1'b1});
			end else begin
				crc = modbus_crc({dev_reg, func_reg, d0, d1, d2, d3});
				pkt = '{dev_reg, func_reg, d0, d1, d2, d3, crc[7:0], crc[15:8], trail_reg};
				for (int i = 0; i < 9; i++)
					pkt_expect_q.push_back({pkt[i], (i == 8), 1'b0});
			end
		end
	endtask

	// stall length: mostly short, now and then long
	function automatic int pick_len();
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// queue one bit and track where the generated frame stands
	task automatic push_bit(input logic [15:0] ticks, input logic start);
		bit_q.push_back({ticks, start});
		gen_bits = start ? 1 : gen_bits + 1;
		if (gen_bits == FRAME_BITS) gen_bits = 0;
	endtask

	// ticks that decode to the wanted bit under the current threshold, often at the edge
	function automatic logic [15:0] ticks_for(input logic b);
		int t;
		t = thr_reg;
		if (b) begin
			if (t >= 65535) return 16'($urandom);
			if ($urandom_range(0, 3) == 0) return 16'(t + 1);
			return 16'($urandom_range(65535, t + 1));
		end
		if ($urandom_range(0, 3) == 0) return 16'(t);
		return 16'($urandom_range(t, 0));
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// 40 bits msb first, start flag on the first bit only
	task automatic add_frame(input logic [39:0] frame, input logic start);
		for (int i = 39; i >= 0; i--)
			push_bit(ticks_for(frame[i]), (i == 39) ? start : 1'b0);
	endtask

	// random stimulus: mostly whole frames, some cut short, some noise
	task automatic fill_random(input int n);
		int          added, k, r;
		logic [31:0] d;
		logic [7:0]  s;
		added = 0;
		while (added < n) begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				d = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
				s = d[31:24] + d[23:16] + d[15:8] + d[7:0];
				if ($urandom_range(0, 3) == 0) s = s ^ 8'($urandom_range(1, 255));
				add_frame({d, s}, (gen_bits == 0) ? 1'($urandom_range(0, 1)) : 1'b1);
				added += 40;
			end else if (r < 8) begin
				k = $urandom_range(1, 39);
				for (int i = 0; i < k; i++)
					push_bit(ticks_for(1'($urandom)), i == 0);
				added += k;
			end else begin
				k = $urandom_range(1, 6);
				for (int i = 0; i < k; i++)
					push_bit(16'($urandom), $urandom_range(0, 3) == 0);
				added += k;
			end
		end
	endtask

	// let every queued bit and expected beat go through, then settle
	task automatic drain();
		while (bit_q.size() != 0 || s_tvalid || pkt_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all four registers while the block is idle
	task automatic load_regs(input logic [15:0] thr, input logic [15:0] dev,
			input logic [15:0] fn, input logic [15:0] tr);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_THRESH;
		cfg_data <= thr;
		@(negedge clk);
		cfg_index <= REG_DEV_ID;
		cfg_data <= dev;
		@(negedge clk);
		cfg_index <= REG_FUNC;
		cfg_data <= fn;
		@(negedge clk);
		cfg_index <= REG_TRAILER;
		cfg_data <= tr;
		@(negedge clk);
		cfg_we <= 1'b0;
		thr_reg = thr;
		dev_reg = dev[7:0];
		func_reg = fn[7:0];
		trail_reg = tr[7:0];
	endtask

	// slave side driver, new beat only after the previous one was taken
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || bit_taken)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (bit_q.size() != 0) begin
				next_bit = bit_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_bit.ticks;
				s_tuser <= next_bit.start;
				if (!tx_quiet && $urandom_range(0, 9) >= 6) tx_gap = pick_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		bit_taken = 1'b0;
	end

	// master side ready with random stalls
	always @(negedge clk) begin
		if (rx_stall > 0) begin
			rx_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!rx_quiet && $urandom_range(0, 3) == 0) rx_stall = pick_len();
		end
	end

	// beat monitor, predictor feed and watchdog
	always @(posedge clk) begin
		pkt_beat_t got, want;
		bit        moved;
		if (arst_n) begin
			moved = 1'b0;
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				got = {m_tdata, m_tlast, m_tuser};
				if (pkt_expect_q.size() == 0) begin
					$display("%0t: unexpected beat, actual data=%h last=%b err=%b",
						$time, got.data, got.last, got.err);
					errors++;
				end else begin
					want = pkt_expect_q.pop_front();
					if (got !== want) begin
						$display("%0t: beat mismatch, expected %h/%b/%b, actual %h/%b/%b",
							$time, want.data, want.last, want.err,
							got.data, got.last, got.err);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				moved = 1'b1;
				bit_taken = 1'b1;
				predict_packet(s_tdata, s_tuser);
			end
			if (moved) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout, no beat for %0d cycles", $time, idle_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// reset, then phases of stimulus with register changes in between
	initial begin
		thr_reg = THRESH_RST;
		dev_reg = DEV_ID_RST;
		func_reg = FUNC_RST;
		trail_reg = TRAILER_RST;
		rx_count = '0;
		rx_frame = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: tick extremes, threshold edge, restart mid-frame
		push_bit(16'd0, 1'b1);
		push_bit(16'hFFFF, 1'b0);
		push_bit(16'd30, 1'b0);
		push_bit(16'd31, 1'b0);
		push_bit(16'hFFFE, 1'b0);
		push_bit(16'd1, 1'b1);
		push_bit(16'h8000, 1'b0);
		push_bit(16'h7FFF, 1'b1);
		push_bit(16'h5555, 1'b0);
		push_bit(16'hAAAA, 1'b0);
		fill_random(16);
		drain();

		// low extremes of the registers but function code 0xff, threshold one
		load_regs(16'd1, 16'h0000, 16'h00FF, 16'h0000);
		fill_random(16);
		drain();

		// top threshold: nothing decodes as one
		load_regs(16'hFFFF, 16'h00FF, 16'h0000, 16'h00FF);
		fill_random(16);
		drain();

		// zero threshold and values wider than the byte registers
		load_regs(16'h0000, 16'($urandom), 16'($urandom), 16'($urandom));
		push_bit(16'd0, 1'b1);
		push_bit(16'd1, 1'b0);
		fill_random(16);
		drain();

		// back to back on both sides
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		load_regs(16'($urandom_range(10, 200)), 16'($urandom), 16'($urandom), 16'($urandom));
		fill_random(16);
		drain();

		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		fill_random(16);
		drain();

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/dhtcrc_pkg.sv
src/dhtcrc_front.sv
src/dhtcrc_queue.sv
src/dhtcrc_back.sv
src/dht11_frame_to_crc16_packet_unit.sv
dv/dht11_frame_to_crc16_packet_unit_tb.sv
